### hw/rtl/drm_pkg.sv
// ============================================================================
// drm_pkg
// Types and constants shared by the DMA descriptor ring manager modules.
// ============================================================================
package drm_pkg;

    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 24;
    localparam int TAG_W    = 16;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;
    localparam int LEVEL_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] NOISE_COUNT_RST = 24'd4096;

    localparam logic [MODE_W-1:0] MODE_APPEND  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_ADDR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_COUNT = 2'd1;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_LINK,
        S_DONE
    } t_state;

    typedef enum logic {
        RING_APPEND,
        RING_ADVANCE
    } t_ring_op;

    typedef struct packed {
        logic     en;
        logic     ch;
        t_ring_op op;
    } t_ring_cmd;

    typedef struct packed {
        logic               valid;
        logic               stop;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  addr;
    } t_desc;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [COUNT_W-1:0]  count;
        logic                stop;
        logic                real_buf;
        logic [TAG_W-1:0]    tag;
    } t_result;

endpackage

### hw/rtl/dma_descriptor_ring_manager.sv
// ============================================================================
// dma_descriptor_ring_manager
// Two scatter-gather descriptor rings (playback, capture) kept in one
// descriptor memory, with append, clear-head and advance-head operations.
// ============================================================================
//
//  channel  direction  handshake                    payload
//  in       in         i_in_valid / o_in_ready      i_mode i_channel i_buffer_*
//  out      out        o_out_valid / i_out_ready    o_status o_slot_* o_head_index
//                                                   o_fill_level
//  cfg      in         i_cfg_valid / o_cfg_ready    i_cfg_index i_cfg_data
//
//  one transaction at a time; idle to idle: append S_READ, S_LINK, S_DONE (S_LINK
//  skipped when the previous slot is empty), clear S_READ, S_DONE, full append,
//  advance and unused mode S_DONE; the descriptor memory's single write port sets
//  the append length; after reset a sweep of all 2 * 2**clog2(RING_SLOTS) entries
//  (64 by default) initializes stop and valid marks; no input transaction during the sweep
//  a stalled result holds in the output register until taken
//
module dma_descriptor_ring_manager #(
    parameter int RING_SLOTS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [drm_pkg::MODE_W-1:0]      i_mode,
    input  logic                            i_channel,
    input  logic [drm_pkg::ADDR_W-1:0]      i_buffer_address,
    input  logic [drm_pkg::COUNT_W-1:0]     i_buffer_count,
    input  logic [drm_pkg::TAG_W-1:0]       i_buffer_tag,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [drm_pkg::STATUS_W-1:0]    o_status,
    output logic [drm_pkg::INDEX_W-1:0]     o_slot_index,
    output logic [drm_pkg::ADDR_W-1:0]      o_slot_address,
    output logic [drm_pkg::COUNT_W-1:0]     o_slot_count,
    output logic                            o_slot_stop,
    output logic                            o_slot_end_of_list,
    output logic                            o_slot_was_real,
    output logic [drm_pkg::TAG_W-1:0]       o_slot_tag,
    output logic [drm_pkg::INDEX_W-1:0]     o_head_index,
    output logic [drm_pkg::LEVEL_W-1:0]     o_fill_level,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [drm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [drm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int SW   = $clog2(RING_SLOTS);
    localparam int LW   = $clog2(RING_SLOTS + 1);
    localparam int AW   = SW + 1;
    localparam int SUMW = LW + 1;

    drm_pkg::t_state r_state, n_state;

    logic [drm_pkg::ADDR_W-1:0]  r_noise_addr;
    logic [drm_pkg::COUNT_W-1:0] r_noise_cnt;

    logic [AW-1:0]               r_sweep;
    logic [drm_pkg::MODE_W-1:0]  r_mode;
    logic                        r_ch;
    logic [SW-1:0]               r_slot, n_slot;
    logic [SW-1:0]               r_prev;
    drm_pkg::t_result            r_res, n_res;

    logic                        r_out_valid;
    drm_pkg::t_result            r_out;
    logic [SW-1:0]               r_out_slot;
    logic [SW-1:0]               r_out_head;
    logic [LW-1:0]               r_out_level;

    logic                        w_acc;
    logic                        w_res_en;
    logic                        w_load_out;
    logic                        w_rd_ch;
    logic [SW-1:0]               w_head;
    logic [LW-1:0]               w_level;
    logic [SUMW-1:0]             w_sum;
    logic [SUMW-1:0]             w_sum_wrap;
    logic [SW-1:0]               w_tail;
    logic [SW-1:0]               w_prev;
    logic                        w_full;

    logic                        w_mem_we;
    logic [AW-1:0]               w_mem_waddr;
    drm_pkg::t_desc              w_mem_wdata;
    logic                        w_mem_re;
    logic [AW-1:0]               w_mem_raddr;
    drm_pkg::t_desc              w_mem_rdata;
    drm_pkg::t_ring_cmd          w_cmd;

    logic [SW+drm_pkg::INDEX_W-1:0] w_slot_ext;
    logic [SW+drm_pkg::INDEX_W-1:0] w_head_ext;
    logic [LW+drm_pkg::LEVEL_W-1:0] w_level_ext;

    // ring head and level
    assign w_rd_ch = (r_state == drm_pkg::S_IDLE) ? i_channel : r_ch;

    drm_ring_state #(
        .RING_SLOTS (RING_SLOTS)
    ) u_ring_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_rd_ch (w_rd_ch),
        .o_head  (w_head),
        .o_level (w_level)
    );

    drm_desc_mem #(
        .AW (AW)
    ) u_desc_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // tail and slot before tail
    assign w_sum      = SUMW'(w_head) + SUMW'(w_level);
    assign w_sum_wrap = (w_sum >= SUMW'(RING_SLOTS)) ? w_sum - SUMW'(RING_SLOTS) : w_sum;
    assign w_tail     = w_sum_wrap[SW-1:0];
    assign w_prev     = (w_tail == '0) ? SW'(RING_SLOTS - 1) : w_tail - SW'(1);
    assign w_full     = (w_level >= LW'(RING_SLOTS));

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_addr <= '0;
            r_noise_cnt  <= drm_pkg::NOISE_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                drm_pkg::CFG_NOISE_ADDR: begin
                    r_noise_addr <= i_cfg_data;
                end
                drm_pkg::CFG_NOISE_COUNT: begin
                    r_noise_cnt <= i_cfg_data[drm_pkg::COUNT_W-1:0];
                end
                default: begin
                    r_noise_addr <= r_noise_addr;
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drm_pkg::S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        w_acc       = 1'b0;
        w_res_en    = 1'b0;
        w_load_out  = 1'b0;
        n_res       = r_res;
        n_slot      = r_slot;
        w_mem_we    = 1'b0;
        w_mem_waddr = {r_ch, r_slot};
        w_mem_wdata = w_mem_rdata;
        w_mem_re    = 1'b0;
        w_mem_raddr = {i_channel, w_head};
        w_cmd       = '{en: 1'b0, ch: i_channel, op: drm_pkg::RING_APPEND};
        case (r_state)
            drm_pkg::S_SWEEP: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_sweep;
                w_mem_wdata = '{valid: 1'b0, stop: 1'b1, tag: '0, count: '0, addr: '0};
                if (r_sweep == '1) begin
                    n_state = drm_pkg::S_IDLE;
                end
            end
            drm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                w_acc      = i_in_valid;
                w_res_en   = i_in_valid;
                n_res      = '{status: drm_pkg::ST_OK, addr: '0, count: '0, stop: 1'b0,
                               real_buf: 1'b0, tag: '0};
                n_slot     = w_head;
                if (i_in_valid) begin
                    case (i_mode)
                        drm_pkg::MODE_APPEND: begin
                            n_slot = w_tail;
                            if (w_full) begin
                                n_res.status = drm_pkg::ST_FULL;
                                n_state      = drm_pkg::S_DONE;
                            end else begin
                                n_res.addr     = i_buffer_address;
                                n_res.count    = i_buffer_count;
                                n_res.tag      = i_buffer_tag;
                                n_res.stop     = 1'b1;
                                n_res.real_buf = 1'b1;
                                w_mem_re       = 1'b1;
                                w_mem_raddr    = {i_channel, w_prev};
                                w_cmd.en       = 1'b1;
                                n_state        = drm_pkg::S_READ;
                            end
                        end
                        drm_pkg::MODE_CLEAR: begin
                            w_mem_re = 1'b1;
                            n_state  = drm_pkg::S_READ;
                        end
                        drm_pkg::MODE_ADVANCE: begin
                            w_cmd.en = 1'b1;
                            w_cmd.op = drm_pkg::RING_ADVANCE;
                            if (w_level == '0) begin
                                n_res.status = drm_pkg::ST_EMPTY;
                            end
                            n_state = drm_pkg::S_DONE;
                        end
                        default: begin
                            n_state = drm_pkg::S_DONE;
                        end
                    endcase
                end
            end
            drm_pkg::S_READ: begin
                w_mem_we = 1'b1;
                if (r_mode == drm_pkg::MODE_APPEND) begin
                    w_mem_wdata = '{valid: 1'b1, stop: 1'b1, tag: r_res.tag,
                                    count: r_res.count, addr: r_res.addr};
                    n_state = w_mem_rdata.valid ? drm_pkg::S_LINK : drm_pkg::S_DONE;
                end else begin
                    w_mem_wdata = '{valid: 1'b0, stop: 1'b1, tag: '0,
                                    count: r_noise_cnt, addr: r_noise_addr};
                    w_res_en       = 1'b1;
                    n_res.real_buf = w_mem_rdata.valid;
                    n_res.stop     = w_mem_rdata.stop;
                    if (w_mem_rdata.valid) begin
                        n_res.addr  = w_mem_rdata.addr;
                        n_res.count = w_mem_rdata.count;
                        n_res.tag   = w_mem_rdata.tag;
                    end else begin
                        n_res.addr  = r_noise_addr;
                        n_res.count = r_noise_cnt;
                        n_res.tag   = '0;
                    end
                    n_state = drm_pkg::S_DONE;
                end
            end
            drm_pkg::S_LINK: begin
                // previous slot loses its stop flag
                w_mem_we         = 1'b1;
                w_mem_waddr      = {r_ch, r_prev};
                w_mem_wdata      = w_mem_rdata;
                w_mem_wdata.stop = 1'b0;
                n_state          = drm_pkg::S_DONE;
            end
            drm_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = drm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = drm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (r_state == drm_pkg::S_SWEEP) begin
            r_sweep <= r_sweep + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mode <= i_mode;
            r_ch   <= i_channel;
            r_slot <= n_slot;
            r_prev <= w_prev;
        end
        if (w_res_en) begin
            r_res <= n_res;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out       <= r_res;
            r_out_slot  <= r_slot;
            r_out_head  <= w_head;
            r_out_level <= w_level;
        end
    end

    assign w_slot_ext  = {{drm_pkg::INDEX_W{1'b0}}, r_out_slot};
    assign w_head_ext  = {{drm_pkg::INDEX_W{1'b0}}, r_out_head};
    assign w_level_ext = {{drm_pkg::LEVEL_W{1'b0}}, r_out_level};

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out.status;
    assign o_slot_index       = w_slot_ext[drm_pkg::INDEX_W-1:0];
    assign o_slot_address     = r_out.addr;
    assign o_slot_count       = r_out.count;
    assign o_slot_stop        = r_out.stop;
    assign o_slot_end_of_list = (r_out_slot == SW'(RING_SLOTS - 1));
    assign o_slot_was_real    = r_out.real_buf;
    assign o_slot_tag         = r_out.tag;
    assign o_head_index       = w_head_ext[drm_pkg::INDEX_W-1:0];
    assign o_fill_level       = w_level_ext[drm_pkg::LEVEL_W-1:0];

    // checks
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LW'(RING_SLOTS))
        else $error("fill level above ring size");

    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_re && w_mem_we))
        else $error("descriptor memory read and write in one cycle");

    a_append_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drm_pkg::S_READ && r_mode == drm_pkg::MODE_APPEND)
            |-> (r_res.status == drm_pkg::ST_OK))
        else $error("memory write for a rejected append");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_state == drm_pkg::S_IDLE && o_out_valid))
        else $error("result load without return to idle");

endmodule

### hw/rtl/drm_desc_mem.sv
// ============================================================================
// drm_desc_mem
// Descriptor memory for both rings, one write and one read port, registered read.
// ============================================================================
module drm_desc_mem #(
    parameter int AW = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  drm_pkg::t_desc  i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output drm_pkg::t_desc  o_rdata
);

    drm_pkg::t_desc r_mem [(1 << AW)];
    drm_pkg::t_desc r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/drm_ring_state.sv
// ============================================================================
// drm_ring_state
// Head index and fill level of the playback and capture rings.
// ============================================================================
module drm_ring_state #(
    parameter int RING_SLOTS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  drm_pkg::t_ring_cmd                i_cmd,
    input  logic                              i_rd_ch,
    output logic [$clog2(RING_SLOTS)-1:0]     o_head,
    output logic [$clog2(RING_SLOTS+1)-1:0]   o_level
);

    localparam int SW = $clog2(RING_SLOTS);
    localparam int LW = $clog2(RING_SLOTS + 1);

    logic [SW-1:0] r_head  [2];
    logic [LW-1:0] r_level [2];
    logic [SW-1:0] w_cur_head;
    logic [LW-1:0] w_cur_level;
    logic [SW-1:0] n_head;
    logic [LW-1:0] n_level;

    assign w_cur_head  = r_head[i_cmd.ch];
    assign w_cur_level = r_level[i_cmd.ch];

    always_comb begin
        n_head  = w_cur_head;
        n_level = w_cur_level;
        case (i_cmd.op)
            drm_pkg::RING_APPEND: begin
                n_level = w_cur_level + LW'(1);
            end
            drm_pkg::RING_ADVANCE: begin
                if (w_cur_level == '0) begin
                    n_head  = '0;
                    n_level = '0;
                end else begin
                    n_head  = (w_cur_head == SW'(RING_SLOTS - 1)) ? '0 : w_cur_head + SW'(1);
                    n_level = w_cur_level - LW'(1);
                end
            end
            default: begin
                n_head  = w_cur_head;
                n_level = w_cur_level;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head[0]  <= '0;
            r_head[1]  <= '0;
            r_level[0] <= '0;
            r_level[1] <= '0;
        end else if (i_cmd.en) begin
            r_head[i_cmd.ch]  <= n_head;
            r_level[i_cmd.ch] <= n_level;
        end
    end

    assign o_head  = r_head[i_rd_ch];
    assign o_level = r_level[i_rd_ch];

endmodule
